>>> rtl/stt_pkg.sv
// Package for the source text tokenizer: lexer modes, token kinds, error codes.
// No dependencies.
`default_nettype none
package stt_pkg;
    localparam int LINE_BITS_DEF   = 16;
    localparam int COLUMN_BITS_DEF = 16;
    localparam int LENGTH_BITS_DEF = 16;
    localparam int KEYWORD_CHARS_DEF = 8;
    localparam int KIND_BITS = 6;
    localparam int ERR_BITS  = 2;

    typedef enum logic [3:0] {
        M_IDLE, M_LCOM, M_BCOM, M_BSTAR, M_SLASH, M_OPER,
        M_NUM, M_NDOT, M_NAME, M_STR, M_ESC
    } mode_t;

    localparam logic [1:0] ERR_NONE = 2'd0;
    localparam logic [1:0] ERR_BCOM = 2'd1;
    localparam logic [1:0] ERR_STR  = 2'd2;
    localparam logic [1:0] ERR_CHAR = 2'd3;

    localparam logic [5:0] K_EOF = 6'd0;
    localparam logic [5:0] K_INT = 6'd1;
    localparam logic [5:0] K_FLOAT = 6'd2;
    localparam logic [5:0] K_STRING = 6'd3;
    localparam logic [5:0] K_IDENT = 6'd4;
    localparam logic [5:0] K_KW0 = 6'd5;
    localparam logic [5:0] K_SLASHEQ = 6'd31;
    localparam logic [5:0] K_SLASH = 6'd32;

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction
    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
    endfunction
    function automatic logic is_space(input logic [7:0] c);
        return c == 8'h20 || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic [5:0] single_kind(input logic [7:0] f);
        case (f)
            "+": return 6'd24;
            "-": return 6'd28;
            "*": return 6'd30;
            "=": return 6'd35;
            "!": return 6'd37;
            "<": return 6'd39;
            ">": return 6'd41;
            "&": return 6'd43;
            "|": return 6'd43;
            default: return 6'd0;
        endcase
    endfunction

    function automatic logic [5:0] pair_kind(input logic [7:0] f, input logic [7:0] s);
        case (f)
            "+": return s == "+" ? 6'd22 : (s == "=" ? 6'd23 : 6'd0);
            "-": return s == ">" ? 6'd25 : (s == "-" ? 6'd26 : (s == "=" ? 6'd27 : 6'd0));
            "*": return s == "=" ? 6'd29 : 6'd0;
            "=": return s == "=" ? 6'd34 : 6'd0;
            "!": return s == "=" ? 6'd36 : 6'd0;
            "<": return s == "=" ? 6'd38 : 6'd0;
            ">": return s == "=" ? 6'd40 : 6'd0;
            "&": return s == "&" ? 6'd42 : 6'd0;
            "|": return s == "|" ? 6'd44 : 6'd0;
            default: return 6'd0;
        endcase
    endfunction

    function automatic logic [5:0] lone_kind(input logic [7:0] c);
        case (c)
            "%": return 6'd33;
            "(": return 6'd45;
            ")": return 6'd46;
            "{": return 6'd47;
            "}": return 6'd48;
            ",": return 6'd49;
            ":": return 6'd50;
            ";": return 6'd51;
            default: return 6'd0;
        endcase
    endfunction

    // keyword table, 8 chars packed, first char in low byte
    localparam int NKW = 17;
    localparam logic [63:0] KW_WORD [NKW] = '{
        64'h000000000074656c, 64'h0000000000006e66, 64'h00006e7275746572,
        64'h0000000000006669, 64'h0000000065736c65, 64'h000000656c696877,
        64'h0000000000726f66, 64'h0000006b61657262, 64'h65756e69746e6f63,
        64'h000000746e697270, 64'h0000000065757274, 64'h00000065736c6166,
        64'h0000000000746e69, 64'h00000074616f6c66, 64'h000000006c6f6f62,
        64'h0000676e69727473, 64'h0000000064696f76
    };
    localparam logic [3:0] KW_LEN [NKW] = '{
        4'd3, 4'd2, 4'd6, 4'd2, 4'd4, 4'd5, 4'd3, 4'd5, 4'd8,
        4'd5, 4'd4, 4'd5, 4'd3, 4'd5, 4'd4, 4'd6, 4'd4
    };
endpackage
`default_nettype wire

>>> rtl/source_text_tokenizer.sv
// Source text tokenizer, top level.
// Channels: in (char_code, char_valid, end_of_source) with in_valid/in_stall;
// out (token fields, error_code, last_result) with out_valid/out_stall.
// One byte is taken per cycle while in_stall is low. Each accepted transaction is decoded by
// combinational logic against the registered lexer state and its results
// (up to three) go into a result queue of four entries; a transaction with no
// result changes only the state. Results enter the queue as the transaction is
// accepted. Throughput is one byte per cycle while results are taken; input
// stalls only when the queue has fewer than three free entries. A stalled
// output holds its transaction. Reset clears the lexer state to between tokens
// at line 1, column 1 and empties the queue. The keyword compare is a constant
// table lookup over the 8-byte name buffer; it is done when the name ends.
// Depends on stt_pkg.
`default_nettype none
module source_text_tokenizer #(
    parameter int LINE_BITS     = stt_pkg::LINE_BITS_DEF,
    parameter int COLUMN_BITS   = stt_pkg::COLUMN_BITS_DEF,
    parameter int LENGTH_BITS   = stt_pkg::LENGTH_BITS_DEF,
    parameter int KEYWORD_CHARS = stt_pkg::KEYWORD_CHARS_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [7:0]             char_code,
    input  wire logic                   char_valid,
    input  wire logic                   end_of_source,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic [stt_pkg::KIND_BITS-1:0] token_kind,
    output logic [LINE_BITS-1:0]        start_line,
    output logic [COLUMN_BITS-1:0]      start_column,
    output logic [LENGTH_BITS-1:0]      token_length,
    output logic [stt_pkg::ERR_BITS-1:0] error_code,
    output logic                        last_result
);
    import stt_pkg::*;

    localparam int KB = 8 * KEYWORD_CHARS;
    localparam int RW = KIND_BITS + LINE_BITS + COLUMN_BITS + LENGTH_BITS + ERR_BITS + 1;
    localparam logic [LINE_BITS-1:0]   LTOP = '1;
    localparam logic [COLUMN_BITS-1:0] CTOP = '1;
    localparam logic [LENGTH_BITS-1:0] NTOP = '1;

    mode_t                  mode_reg, mode_next;
    logic [LINE_BITS-1:0]   line_reg, line_next, tline_reg, tline_next;
    logic [COLUMN_BITS-1:0] col_reg, col_next, tcol_reg, tcol_next;
    logic [LENGTH_BITS-1:0] cnt_reg, cnt_next;
    logic [KB-1:0]          kw_reg, kw_next;
    logic                   flt_reg, flt_next, err_reg, err_next;

    logic [RW-1:0] q_mem [4];
    logic [1:0]    wr_reg, rd_reg;
    logic [2:0]    fill_reg;
    logic [RW-1:0] res [3];
    logic [1:0]    nres;
    logic          acc, pop;

    assign in_stall = fill_reg > 3'd1;
    assign acc = in_valid && !in_stall;
    assign out_valid = fill_reg != 3'd0;
    assign pop = out_valid && !out_stall;
    assign {token_kind, start_line, start_column, token_length, error_code, last_result}
        = q_mem[rd_reg];

    always_comb
    begin
        logic [7:0] c;
        logic       take;
        logic [5:0] k, kind;
        logic [COLUMN_BITS:0] dc;
        logic [RW-1:0] r [3];
        logic [1:0] n;
        logic       fl;
        c = char_code;
        mode_next = mode_reg; line_next = line_reg; col_next = col_reg;
        tline_next = tline_reg; tcol_next = tcol_reg; cnt_next = cnt_reg;
        kw_next = kw_reg; flt_next = flt_reg; err_next = err_reg;
        n = 2'd0;
        for (int i = 0; i < 3; i++) r[i] = '0;
        take = 1'b0;
        fl = 1'b0;
        k = 6'd0;
        kind = K_IDENT;
        for (int i = NKW - 1; i >= 0; i--)
            if (KW_LEN[i] <= KEYWORD_CHARS && cnt_reg == LENGTH_BITS'(KW_LEN[i])
                && kw_reg[63:0] == KW_WORD[i])
                kind = K_KW0 + 6'(i);
        dc = {1'b0, tcol_reg} + (COLUMN_BITS+1)'(cnt_reg);
        if (dc > {1'b0, CTOP}) dc = {1'b0, CTOP};

        if (!err_reg && char_valid) begin
            fl = 1'b0;
            case (mode_reg)
                M_LCOM: if (c == 8'h0a) mode_next = M_IDLE;
                M_BCOM: if (c == "*") mode_next = M_BSTAR;
                M_BSTAR:
                begin
                    if (c == "/") mode_next = M_IDLE;
                    else if (c != "*") mode_next = M_BCOM;
                end
                M_SLASH:
                begin
                    if (c == "/") mode_next = M_LCOM;
                    else if (c == "*") mode_next = M_BCOM;
                    else if (c == "=") begin
                        r[0] = {K_SLASHEQ, tline_reg, tcol_reg,
                                (cnt_reg == NTOP) ? cnt_reg : cnt_reg + 1'b1, ERR_NONE, 1'b0};
                        n = 2'd1; mode_next = M_IDLE;
                    end else begin
                        r[0] = {K_SLASH, tline_reg, tcol_reg, cnt_reg, ERR_NONE, 1'b0};
                        n = 2'd1; take = 1'b1;
                    end
                end
                M_OPER:
                begin
                    k = pair_kind(kw_reg[7:0], c);
                    if (k != 6'd0) begin
                        r[0] = {k, tline_reg, tcol_reg,
                                (cnt_reg == NTOP) ? cnt_reg : cnt_reg + 1'b1, ERR_NONE, 1'b0};
                        n = 2'd1; mode_next = M_IDLE;
                    end else begin
                        r[0] = {single_kind(kw_reg[7:0]), tline_reg, tcol_reg, cnt_reg,
                                ERR_NONE, 1'b0};
                        n = 2'd1; take = 1'b1;
                    end
                end
                M_NUM:
                begin
                    if (is_digit(c)) begin
                        if (cnt_reg != NTOP) cnt_next = cnt_reg + 1'b1;
                    end else if (c == "." && !flt_reg) mode_next = M_NDOT;
                    else if (c == "f" || c == "F") begin
                        r[0] = {K_FLOAT, tline_reg, tcol_reg,
                                (cnt_reg == NTOP) ? cnt_reg : cnt_reg + 1'b1, ERR_NONE, 1'b0};
                        n = 2'd1; mode_next = M_IDLE;
                    end else begin
                        r[0] = {flt_reg ? K_FLOAT : K_INT, tline_reg, tcol_reg, cnt_reg,
                                ERR_NONE, 1'b0};
                        n = 2'd1; take = 1'b1;
                    end
                end
                M_NDOT:
                begin
                    if (is_digit(c)) begin
                        flt_next = 1'b1; mode_next = M_NUM;
                        if (cnt_reg >= NTOP - 1'b1) cnt_next = NTOP;
                        else cnt_next = cnt_reg + 2'd2;
                    end else begin
                        r[0] = {K_INT, tline_reg, tcol_reg, cnt_reg, ERR_NONE, 1'b0};
                        r[1] = {K_EOF, tline_reg, dc[COLUMN_BITS-1:0], {LENGTH_BITS{1'b0}},
                                ERR_CHAR, 1'b0};
                        n = 2'd2; err_next = 1'b1; fl = 1'b1;
                    end
                end
                M_NAME:
                begin
                    if (is_alpha(c) || is_digit(c) || c == "_") begin
                        for (int i = 0; i < KEYWORD_CHARS; i++)
                            if (cnt_reg == LENGTH_BITS'(i)) kw_next[8*i +: 8] = c;
                        if (cnt_reg != NTOP) cnt_next = cnt_reg + 1'b1;
                    end else begin
                        r[0] = {kind, tline_reg, tcol_reg, cnt_reg, ERR_NONE, 1'b0};
                        n = 2'd1; take = 1'b1;
                    end
                end
                M_STR:
                begin
                    if (cnt_reg != NTOP) cnt_next = cnt_reg + 1'b1;
                    if (c == 8'h22) begin
                        r[0] = {K_STRING, tline_reg, tcol_reg,
                                (cnt_reg == NTOP) ? cnt_reg : cnt_reg + 1'b1, ERR_NONE, 1'b0};
                        n = 2'd1; mode_next = M_IDLE;
                    end else if (c == 8'h5c) mode_next = M_ESC;
                end
                M_ESC:
                begin
                    if (cnt_reg != NTOP) cnt_next = cnt_reg + 1'b1;
                    mode_next = M_STR;
                end
                default: take = 1'b1;
            endcase
            if (take) begin
                tline_next = line_reg; tcol_next = col_reg;
                cnt_next = LENGTH_BITS'(1);
                mode_next = M_IDLE;
                if (is_space(c)) begin
                end else if (c == "/") mode_next = M_SLASH;
                else if (is_digit(c)) begin
                    flt_next = 1'b0; mode_next = M_NUM;
                end else if (c == 8'h22) mode_next = M_STR;
                else if (is_alpha(c) || c == "_" || single_kind(c) != 6'd0) begin
                    kw_next = '0; kw_next[7:0] = c;
                    mode_next = (single_kind(c) != 6'd0) ? M_OPER : M_NAME;
                end else if (lone_kind(c) != 6'd0) begin
                    r[n] = {lone_kind(c), line_reg, col_reg, LENGTH_BITS'(1), ERR_NONE, 1'b0};
                    n = n + 1'b1;
                end else begin
                    r[n] = {K_EOF, line_reg, col_reg, {LENGTH_BITS{1'b0}}, ERR_CHAR, 1'b0};
                    n = n + 1'b1; err_next = 1'b1; fl = 1'b1;
                end
            end
            if (!fl) begin
                if (c == 8'h0a) begin
                    if (line_reg != LTOP) line_next = line_reg + 1'b1;
                    col_next = COLUMN_BITS'(1);
                end else if (col_reg != CTOP) col_next = col_reg + 1'b1;
            end
        end

        if (!err_next && end_of_source) begin
            fl = 1'b1;
            case (mode_next)
                M_BCOM, M_BSTAR:
                begin
                    r[n] = {K_EOF, tline_next, tcol_next, {LENGTH_BITS{1'b0}}, ERR_BCOM, 1'b0};
                    n = n + 1'b1; fl = 1'b0;
                end
                M_STR, M_ESC:
                begin
                    r[n] = {K_EOF, tline_next, tcol_next, {LENGTH_BITS{1'b0}}, ERR_STR, 1'b0};
                    n = n + 1'b1; fl = 1'b0;
                end
                M_NDOT:
                begin
                    r[n] = {K_INT, tline_next, tcol_next, cnt_next, ERR_NONE, 1'b0};
                    dc = {1'b0, tcol_next} + (COLUMN_BITS+1)'(cnt_next);
                    if (dc > {1'b0, CTOP}) dc = {1'b0, CTOP};
                    r[n+1] = {K_EOF, tline_next, dc[COLUMN_BITS-1:0], {LENGTH_BITS{1'b0}},
                              ERR_CHAR, 1'b0};
                    n = n + 2'd2; fl = 1'b0;
                end
                M_SLASH:
                begin
                    r[n] = {K_SLASH, tline_next, tcol_next, cnt_next, ERR_NONE, 1'b0};
                    n = n + 1'b1;
                end
                M_OPER:
                begin
                    r[n] = {single_kind(kw_next[7:0]), tline_next, tcol_next, cnt_next,
                            ERR_NONE, 1'b0};
                    n = n + 1'b1;
                end
                M_NUM:
                begin
                    r[n] = {flt_next ? K_FLOAT : K_INT, tline_next, tcol_next, cnt_next,
                            ERR_NONE, 1'b0};
                    n = n + 1'b1;
                end
                M_NAME:
                begin
                    // name buffer and length have changed here if the name was just started
                    // or extended; recompute the keyword match on next state
                    kind = K_IDENT;
                    for (int i = NKW - 1; i >= 0; i--)
                        if (KW_LEN[i] <= KEYWORD_CHARS && cnt_next == LENGTH_BITS'(KW_LEN[i])
                            && kw_next[63:0] == KW_WORD[i])
                            kind = K_KW0 + 6'(i);
                    r[n] = {kind, tline_next, tcol_next, cnt_next, ERR_NONE, 1'b0};
                    n = n + 1'b1;
                end
                default: ;
            endcase
            if (fl) begin
                r[n] = {K_EOF, line_next, col_next, {LENGTH_BITS{1'b0}}, ERR_NONE, 1'b0};
                n = n + 1'b1;
            end
        end
        if (end_of_source) begin
            mode_next = M_IDLE; line_next = LINE_BITS'(1); col_next = COLUMN_BITS'(1);
            tline_next = LINE_BITS'(1); tcol_next = COLUMN_BITS'(1); cnt_next = '0;
            kw_next = '0; flt_next = 1'b0; err_next = 1'b0;
        end
        if (n != 2'd0) r[n - 1'b1][0] = 1'b1;
        for (int i = 0; i < 3; i++) res[i] = r[i];
        nres = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg <= M_IDLE;
            line_reg <= LINE_BITS'(1);
            col_reg <= COLUMN_BITS'(1);
            tline_reg <= LINE_BITS'(1);
            tcol_reg <= COLUMN_BITS'(1);
            cnt_reg <= '0;
            kw_reg <= '0;
            flt_reg <= 1'b0;
            err_reg <= 1'b0;
            wr_reg <= '0;
            rd_reg <= '0;
            fill_reg <= '0;
        end else begin
            if (acc) begin
                mode_reg <= mode_next; line_reg <= line_next; col_reg <= col_next;
                tline_reg <= tline_next; tcol_reg <= tcol_next; cnt_reg <= cnt_next;
                kw_reg <= kw_next; flt_reg <= flt_next; err_reg <= err_next;
                wr_reg <= wr_reg + nres;
            end
            if (pop) rd_reg <= rd_reg + 1'b1;
            fill_reg <= fill_reg + (acc ? {1'b0, nres} : 3'd0) - {2'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
            for (int i = 0; i < 3; i++)
                if (2'(i) < nres) q_mem[wr_reg + 2'(i)] <= res[i];
    end
endmodule
`default_nettype wire

>>> rtl/stt_checker.sv
// Port-level checker for the source text tokenizer, bound to the top level.
// Depends on source_text_tokenizer ports only.
`default_nettype none
module stt_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [1:0] error_code,
    input wire logic [5:0] token_kind,
    input wire logic [15:0] token_length,
    input wire logic [15:0] start_line
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(token_kind))
        else $error("stalled transaction changed");
    a_err_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error_code != 2'd0 |-> token_kind == 6'd0 && token_length == 16'd0)
        else $error("error result with token fields");
    a_line: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> start_line != 16'd0)
        else $error("line zero");
    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> token_kind <= 6'd51)
        else $error("bad kind");
endmodule

bind source_text_tokenizer stt_checker u_stt_checker (
    .clk(clk), .rst_n(rst_n),
    .out_valid(out_valid), .out_stall(out_stall), .error_code(error_code),
    .token_kind(token_kind), .token_length(token_length), .start_line(start_line)
);
`default_nettype wire

>>> tb/tb.sv
// Testbench for source_text_tokenizer: byte streams in, tokens checked in order.
// Carries its own lexer predictor and a result queue; depends on stt_pkg and the RTL.
`timescale 1ns / 100ps
module tb;
    import stt_pkg::*;

    localparam logic [5:0] T_INC = 6'd22, T_ADDEQ = 6'd23, T_ADD = 6'd24, T_ARROW = 6'd25;
    localparam logic [5:0] T_DEC = 6'd26, T_SUBEQ = 6'd27, T_SUB = 6'd28, T_MULEQ = 6'd29;
    localparam logic [5:0] T_MUL = 6'd30, T_MOD = 6'd33, T_EQEQ = 6'd34, T_ASSIGN = 6'd35;
    localparam logic [5:0] T_NE = 6'd36, T_NOT = 6'd37, T_LE = 6'd38, T_LT = 6'd39;
    localparam logic [5:0] T_GE = 6'd40, T_GT = 6'd41, T_ANDAND = 6'd42, T_BAD = 6'd43;
    localparam logic [5:0] T_OROR = 6'd44, T_LPAR = 6'd45, T_RPAR = 6'd46, T_LBR = 6'd47;
    localparam logic [5:0] T_RBR = 6'd48, T_COMMA = 6'd49, T_COLON = 6'd50, T_SEMI = 6'd51;
    localparam int TOP = 65535;
    localparam int NAME_CHARS = 8;
    localparam int MAX_TOK = 3;

    typedef struct {
        logic [5:0]  kind;
        logic [15:0] ln;
        logic [15:0] cl;
        logic [15:0] len;
        logic [1:0]  err;
        logic        last;
    } tok_t;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        in_valid = 0;
    logic        in_stall;
    logic [7:0]  char_code = 0;
    logic        char_valid = 0;
    logic        end_of_source = 0;
    logic        out_valid;
    logic        out_stall = 0;
    logic [5:0]  token_kind;
    logic [15:0] start_line, start_column, token_length;
    logic [1:0]  error_code;
    logic        last_result;

    source_text_tokenizer i_dut (.*);

    always #2 clk = ~clk;

    // predictor state
    mode_t    md;
    int       cur_ln, cur_cl, tok_ln, tok_cl, tok_cnt;
    byte unsigned name_buf [NAME_CHARS];
    bit       is_flt, err_lat;
    tok_t     item_toks[$];
    tok_t     token_q[$];
    string    kw_list [17] = '{"let", "fn", "return", "if", "else", "while", "for", "break",
        "continue", "print", "true", "false", "int", "float", "bool", "string", "void"};

    int fails = 0;
    int mism = 0;

    function automatic bit dig(byte unsigned c); return c >= "0" && c <= "9"; endfunction
    function automatic bit alp(byte unsigned c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction
    function automatic bit spc(byte unsigned c); return c == " " || (c >= 9 && c <= 13); endfunction

    function automatic logic [5:0] op1(byte unsigned f);
        case (f)
            "+": return T_ADD;
            "-": return T_SUB;
            "*": return T_MUL;
            "=": return T_ASSIGN;
            "!": return T_NOT;
            "<": return T_LT;
            ">": return T_GT;
            "&", "|": return T_BAD;
            default: return K_EOF;
        endcase
    endfunction

    function automatic logic [5:0] op2(byte unsigned f, byte unsigned s);
        case (f)
            "+": return s == "+" ? T_INC : (s == "=" ? T_ADDEQ : K_EOF);
            "-": return s == ">" ? T_ARROW : (s == "-" ? T_DEC : (s == "=" ? T_SUBEQ : K_EOF));
            "*": return s == "=" ? T_MULEQ : K_EOF;
            "=": return s == "=" ? T_EQEQ : K_EOF;
            "!": return s == "=" ? T_NE : K_EOF;
            "<": return s == "=" ? T_LE : K_EOF;
            ">": return s == "=" ? T_GE : K_EOF;
            "&": return s == "&" ? T_ANDAND : K_EOF;
            "|": return s == "|" ? T_OROR : K_EOF;
            default: return K_EOF;
        endcase
    endfunction

    function automatic logic [5:0] punct(byte unsigned c);
        case (c)
            "%": return T_MOD;
            "(": return T_LPAR;
            ")": return T_RPAR;
            "{": return T_LBR;
            "}": return T_RBR;
            ",": return T_COMMA;
            ":": return T_COLON;
            ";": return T_SEMI;
            default: return K_EOF;
        endcase
    endfunction

    function automatic void put(logic [5:0] k, int l, int c, int n, logic [1:0] e);
        tok_t t;
        if (item_toks.size() >= MAX_TOK)
            return;
        t.kind = k; t.ln = 16'(l); t.cl = 16'(c); t.len = 16'(n); t.err = e; t.last = 0;
        item_toks.insert(item_toks.size(), t);
    endfunction

    function automatic void put_tok(logic [5:0] k);
        put(k, tok_ln, tok_cl, tok_cnt, ERR_NONE);
    endfunction

    function automatic void put_name();
        logic [5:0] k;
        bit hit;
        k = K_IDENT;
        for (int i = 0; i < 17; i++) begin
            hit = tok_cnt == kw_list[i].len() && kw_list[i].len() <= NAME_CHARS;
            for (int j = 0; hit && j < kw_list[i].len(); j++)
                if (name_buf[j] != kw_list[i][j])
                    hit = 0;
            if (hit && k == K_IDENT)
                k = K_KW0 + 6'(i);
        end
        put_tok(k);
    endfunction

    function automatic void dot_fail();
        int c;
        c = tok_cl + tok_cnt;
        if (c > TOP)
            c = TOP;
        put_tok(K_INT);
        put(K_EOF, tok_ln, c, 0, ERR_CHAR);
        err_lat = 1;
    endfunction

    function automatic void bump();
        if (tok_cnt < TOP)
            tok_cnt++;
    endfunction

    function automatic void advance(byte unsigned c);
        if (c == 8'h0a) begin
            if (cur_ln < TOP)
                cur_ln++;
            cur_cl = 1;
        end else if (cur_cl < TOP)
            cur_cl++;
    endfunction

    function automatic void clear_name(byte unsigned c);
        foreach (name_buf[i])
            name_buf[i] = 0;
        name_buf[0] = c;
    endfunction

    function automatic void begin_tok(byte unsigned c);
        tok_ln = cur_ln;
        tok_cl = cur_cl;
        tok_cnt = 1;
        md = M_IDLE;
        if (spc(c)) begin
        end else if (c == "/")
            md = M_SLASH;
        else if (dig(c)) begin
            is_flt = 0;
            md = M_NUM;
        end else if (c == "\"")
            md = M_STR;
        else if (alp(c) || c == "_") begin
            clear_name(c);
            md = M_NAME;
        end else if (op1(c) != K_EOF) begin
            clear_name(c);
            md = M_OPER;
        end else if (punct(c) != K_EOF)
            put_tok(punct(c));
        else begin
            put(K_EOF, tok_ln, tok_cl, 0, ERR_CHAR);
            err_lat = 1;
            return;
        end
        advance(c);
    endfunction

    function automatic void lex_byte(byte unsigned c);
        logic [5:0] k;
        case (md)
            M_LCOM: begin
                if (c == 8'h0a)
                    md = M_IDLE;
                advance(c);
                return;
            end
            M_BCOM: begin
                if (c == "*")
                    md = M_BSTAR;
                advance(c);
                return;
            end
            M_BSTAR: begin
                if (c == "/")
                    md = M_IDLE;
                else if (c != "*")
                    md = M_BCOM;
                advance(c);
                return;
            end
            M_SLASH: begin
                if (c == "/" || c == "*") begin
                    md = c == "/" ? M_LCOM : M_BCOM;
                    advance(c);
                    return;
                end
                if (c == "=") begin
                    bump();
                    put_tok(K_SLASHEQ);
                    md = M_IDLE;
                    advance(c);
                    return;
                end
                put_tok(K_SLASH);
            end
            M_OPER: begin
                k = op2(name_buf[0], c);
                if (k != K_EOF) begin
                    bump();
                    put_tok(k);
                    md = M_IDLE;
                    advance(c);
                    return;
                end
                put_tok(op1(name_buf[0]));
            end
            M_NUM: begin
                if (dig(c)) begin
                    bump();
                    advance(c);
                    return;
                end
                if (c == "." && !is_flt) begin
                    md = M_NDOT;
                    advance(c);
                    return;
                end
                if (c == "f" || c == "F") begin
                    bump();
                    put_tok(K_FLOAT);
                    md = M_IDLE;
                    advance(c);
                    return;
                end
                put_tok(is_flt ? K_FLOAT : K_INT);
            end
            M_NDOT: begin
                if (dig(c)) begin
                    is_flt = 1;
                    bump();
                    bump();
                    md = M_NUM;
                    advance(c);
                    return;
                end
                dot_fail();
                return;
            end
            M_NAME: begin
                if (alp(c) || dig(c) || c == "_") begin
                    if (tok_cnt < NAME_CHARS)
                        name_buf[tok_cnt] = c;
                    bump();
                    advance(c);
                    return;
                end
                put_name();
            end
            M_STR: begin
                bump();
                if (c == "\"") begin
                    put_tok(K_STRING);
                    md = M_IDLE;
                end else if (c == "\\")
                    md = M_ESC;
                advance(c);
                return;
            end
            M_ESC: begin
                bump();
                md = M_STR;
                advance(c);
                return;
            end
            default: ;
        endcase
        begin_tok(c);
    endfunction

    function automatic void flush_src();
        case (md)
            M_BCOM, M_BSTAR: begin
                put(K_EOF, tok_ln, tok_cl, 0, ERR_BCOM);
                return;
            end
            M_STR, M_ESC: begin
                put(K_EOF, tok_ln, tok_cl, 0, ERR_STR);
                return;
            end
            M_NDOT: begin
                dot_fail();
                return;
            end
            M_SLASH: put_tok(K_SLASH);
            M_OPER:  put_tok(op1(name_buf[0]));
            M_NUM:   put_tok(is_flt ? K_FLOAT : K_INT);
            M_NAME:  put_name();
            default: ;
        endcase
        put(K_EOF, cur_ln, cur_cl, 0, ERR_NONE);
    endfunction

    function automatic void lexer_clear();
        md = M_IDLE;
        cur_ln = 1; cur_cl = 1; tok_ln = 1; tok_cl = 1; tok_cnt = 0;
        foreach (name_buf[i])
            name_buf[i] = 0;
        is_flt = 0;
        err_lat = 0;
    endfunction

    function automatic void predict(byte unsigned c, bit v, bit e);
        item_toks.delete();
        if (!err_lat && v)
            lex_byte(c);
        if (!err_lat && e)
            flush_src();
        if (e)
            lexer_clear();
        if (item_toks.size() > 0)
            item_toks[item_toks.size() - 1].last = 1;
        foreach (item_toks[i])
            token_q.insert(token_q.size(), item_toks[i]);
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_item(byte unsigned c, bit v, bit e);
        int g;
        bit acc;
        predict(c, v, e);
        g = gap_len();
        if (g > 0)
        begin
            in_valid <= 0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1;
        char_code <= c;
        char_valid <= v;
        end_of_source <= e;
        do
        begin
            @(negedge clk);
            acc = !in_stall;
            @(posedge clk);
        end while (!acc);
    endtask

    task automatic send_text(string s, bit close);
        for (int i = 0; i < s.len(); i++)
            send_item(s[i], 1, close && i == s.len() - 1);
    endtask

    task automatic drain_tokens();
        in_valid <= 0;
        while (token_q.size() > 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // result side
    initial
    begin
        int stall_left;
        tok_t t;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (token_q.size() == 0)
                begin
                    fails++;
                    if (mism < 10)
                        $display("unexpected transaction kind %0d", token_kind);
                    mism++;
                end else begin
                    t = token_q.pop_front();
                    if (token_kind !== t.kind || start_line !== t.ln || start_column !== t.cl ||
                        token_length !== t.len || error_code !== t.err ||
                        last_result !== t.last)
                    begin
                        fails++;
                        if (mism < 10)
                            $display({"mismatch exp %0d %0d:%0d len %0d err %0d last %0d, ",
                                "got %0d %0d:%0d len %0d err %0d last %0d"},
                                t.kind, t.ln, t.cl, t.len, t.err, t.last, token_kind,
                                start_line, start_column, token_length, error_code, last_result);
                        mism++;
                    end
                end
            end
            @(posedge clk);
            if (stall_left > 0)
                stall_left--;
            else
                stall_left = gap_len();
            out_stall <= stall_left > 0;
        end
    end

    task automatic test_directed();
        send_text("fn x+=2.5f", 1);
        send_text("\"a\\", 1);
        send_text("/*x", 1);
        send_text("1.", 1);
        send_item(8'hff, 1, 0);
        send_item(8'h00, 1, 1);
        send_item(8'h00, 1, 0);
        send_item(8'h41, 0, 0);
        send_item(8'h00, 0, 1);
        send_text("7.x", 1);
    endtask

    function automatic void add_byte(ref byte unsigned q[$], input int v);
        q.insert(q.size(), 8'(v));
    endfunction

    function automatic void add_text(ref byte unsigned q[$], input string s);
        for (int i = 0; i < s.len(); i++)
            add_byte(q, s[i]);
    endfunction

    function automatic void make_piece(ref byte unsigned q[$]);
        string ops [30] = '{"++", "+=", "+", "->", "--", "-=", "-", "*=", "*", "/=", "/",
            "%", "==", "=", "!=", "!", "<=", "<", ">=", ">", "&&", "&", "||", "|",
            "(", ")", "{", "}", ",", ":"};
        string ws = " \t\n\r";
        int n;
        int b;
        case ($urandom_range(0, 10))
            0: add_text(q, kw_list[$urandom_range(0, 16)]);
            1, 2: begin
                n = $urandom_range(1, 11);
                add_byte(q, $urandom_range(0, 1) ? "_" : "a" + $urandom_range(0, 25));
                repeat (n - 1)
                    add_byte(q, $urandom_range(0, 2) == 0 ? "0" + $urandom_range(0, 9) :
                        ($urandom_range(0, 1) ? "A" : "a") + $urandom_range(0, 25));
            end
            3: begin
                repeat ($urandom_range(1, 4)) add_byte(q, "0" + $urandom_range(0, 9));
                if ($urandom_range(0, 1))
                begin
                    add_byte(q, ".");
                    repeat ($urandom_range(1, 3)) add_byte(q, "0" + $urandom_range(0, 9));
                end
                if ($urandom_range(0, 2) == 0)
                    add_byte(q, $urandom_range(0, 1) ? "f" : "F");
            end
            4: begin
                add_byte(q, "\"");
                repeat ($urandom_range(0, 5))
                    if ($urandom_range(0, 3) == 0)
                    begin
                        add_byte(q, "\\");
                        add_byte(q, $urandom_range(32, 126));
                    end else
                    begin
                        b = $urandom_range(35, 126);
                        add_byte(q, b == "\\" ? "x" : b);
                    end
                add_byte(q, "\"");
            end
            5, 6: add_text(q, $urandom_range(0, 7) == 0 ? ";" : ops[$urandom_range(0, 29)]);
            7: begin
                add_text(q, "//");
                repeat ($urandom_range(0, 4))
                begin
                    b = $urandom_range(0, 255);
                    add_byte(q, b == 10 ? 8'h20 : b);
                end
                add_byte(q, 8'h0a);
            end
            8: begin
                add_text(q, "/*");
                repeat ($urandom_range(0, 4))
                    add_byte(q, $urandom_range(0, 1) ? "*" : $urandom_range(0, 255));
                add_text(q, "*/");
            end
            9: add_byte(q, $urandom_range(0, 255));
            default: add_byte(q, $urandom_range(9, 13));
        endcase
        add_byte(q, ws[$urandom_range(0, 3)]);
    endfunction

    task automatic test_random();
        byte unsigned q[$];
        int sent;
        bit paused;
        sent = 0;
        paused = 0;
        while (sent < 250)
        begin
            q.delete();
            make_piece(q);
            foreach (q[i])
            begin
                send_item(q[i], 1, 0);
                sent++;
                if (err_lat)
                    break;
            end
            if (err_lat || $urandom_range(0, 12) == 0)
            begin
                if (err_lat)
                    repeat ($urandom_range(0, 2))
                        send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 0);
                send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1);
            end
            if ($urandom_range(0, 30) == 0)
                send_item(8'($urandom_range(0, 255)), 0, 0);
            if (!paused && sent > 140)
            begin
                drain_tokens();
                paused = 1;
            end
        end
        send_item(8'h00, 0, 1);
    endtask

    initial
    begin
        lexer_clear();
        repeat (11) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        test_directed();
        test_random();
        drain_tokens();
        repeat (20) @(posedge clk);
        if (fails == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("tb failed");
        $finish;
    end
endmodule

>>> files.f
rtl/stt_pkg.sv
rtl/source_text_tokenizer.sv
rtl/stt_checker.sv
tb/tb.sv
